[sv/npg_pkg.sv]
// ----------------------------------------------------------------------------
// npg_pkg
// Shared types and constants of the next permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package npg_pkg;

    // default storage shape
    localparam int MAX_ELEMS_DEF = 8;
    localparam int ELEM_BITS_DEF = 16;

    // fixed field widths at the ports
    localparam int OP_W     = 1;
    localparam int IDX_FW   = 3;
    localparam int VAL_FW   = 16;
    localparam int COUNT_FW = 4;
    localparam int TDATA_W  = 24;

    localparam logic [COUNT_FW-1:0] ELEM_COUNT_RST = 4'd8;

    // item kinds
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_STEP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SUCC_RD,
        ST_SUCC_CMP,
        ST_SWAP2,
        ST_REV_RD,
        ST_REV_W1,
        ST_REV_W2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } npg_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } npg_mem_ctl_t;

endpackage : npg_pkg

`default_nettype wire

[sv/npg_mem.sv]
// ----------------------------------------------------------------------------
// npg_mem
// Element store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  wire logic                 aclk,
    input  wire npg_pkg::npg_mem_ctl_t ctl,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [AW-1:0]        rd_addr_a,
    input  wire logic [AW-1:0]        rd_addr_b,
    output logic      [WIDTH-1:0]     rd_data_a,
    output logic      [WIDTH-1:0]     rd_data_b
);
    import npg_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule : npg_mem

`default_nettype wire

[sv/npg_ctrl.sv]
// ----------------------------------------------------------------------------
// npg_ctrl
// Sequencer with one shared comparator: element loads, ascent scan, successor scan, swap,
// tail reversal and element readout.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_ctrl #(
    parameter int MAX_ELEMS = 8,
    parameter int ELEM_BITS = 16,
    parameter int AW        = 3,
    parameter int CNT_W     = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_accept,
    input  wire logic [npg_pkg::OP_W-1:0]      in_op,
    input  wire logic [npg_pkg::IDX_FW-1:0]    in_idx,
    input  wire logic [npg_pkg::VAL_FW-1:0]    in_val,
    input  wire logic [npg_pkg::COUNT_FW-1:0]  elem_count,
    output logic                               in_ready,
    output npg_pkg::npg_mem_ctl_t              mem_ctl,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [ELEM_BITS-1:0]          wr_data,
    output logic      [AW-1:0]                 rd_addr_a,
    output logic      [AW-1:0]                 rd_addr_b,
    input  wire logic [ELEM_BITS-1:0]          rd_data_a,
    input  wire logic [ELEM_BITS-1:0]          rd_data_b,
    input  wire logic                          out_free,
    output logic                               out_load,
    output logic      [AW-1:0]                 out_pos,
    output logic      [ELEM_BITS-1:0]          out_elem,
    output logic                               out_adv,
    output logic                               out_last
);
    import npg_pkg::*;

    localparam int CW = (CNT_W > COUNT_FW) ? CNT_W : COUNT_FW;

    npg_state_t           state_reg, state_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        p_reg, p_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [ELEM_BITS-1:0] pv_reg, pv_next;
    logic                 adv_reg, adv_next;

    logic [CW-1:0]        cnt_w;
    logic [CNT_W-1:0]     len;
    logic [AW-1:0]        n_last;
    logic [ELEM_BITS-1:0] cmp_x;
    logic [ELEM_BITS-1:0] cmp_y;
    logic                 cmp_lt;

    // zero counts as one, too large saturates
    always_comb begin
        cnt_w = CW'(elem_count);
        if (cnt_w == '0) begin
            len = CNT_W'(1);
        end else if (cnt_w > CW'(MAX_ELEMS)) begin
            len = CNT_W'(MAX_ELEMS);
        end else begin
            len = CNT_W'(cnt_w);
        end
    end

    assign n_last = AW'(n_reg - 1'b1);

    // the shared comparator
    always_comb begin
        case (state_reg)
            ST_SUCC_CMP: begin
                cmp_x = pv_reg;
                cmp_y = rd_data_a;
            end
            default: begin
                cmp_x = rd_data_a;
                cmp_y = rd_data_b;
            end
        endcase
    end

    assign cmp_lt = cmp_x < cmp_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            adv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            adv_reg   <= adv_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg  <= k_next;
        p_reg  <= p_next;
        j_reg  <= j_next;
        lo_reg <= lo_next;
        n_reg  <= n_next;
        pv_reg <= pv_next;
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        j_next        = j_reg;
        lo_next       = lo_reg;
        n_next        = n_reg;
        pv_next       = pv_reg;
        adv_next      = adv_reg;
        in_ready      = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        wr_addr       = k_reg;
        wr_data       = rd_data_a;
        rd_addr_a     = k_reg;
        rd_addr_b     = k_reg;
        out_load      = 1'b0;
        out_pos       = k_reg;
        out_elem      = rd_data_a;
        out_adv       = adv_reg;
        out_last      = (k_reg == n_last);

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    if (in_op == OP_STEP) begin
                        n_next     = len;
                        k_next     = AW'(len - 1'b1);
                        state_next = ST_FIND_RD;
                    end else if (32'(in_idx) < MAX_ELEMS) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = AW'(in_idx);
                        wr_data       = ELEM_BITS'(in_val);
                    end
                end
            end
            ST_FIND_RD: begin
                if (k_reg == '0) begin
                    // no ascent: last permutation or a single element
                    adv_next   = 1'b0;
                    state_next = ST_EMIT_RD;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr_a     = AW'(k_reg - 1'b1);
                    rd_addr_b     = k_reg;
                    state_next    = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP: begin
                if (cmp_lt) begin
                    p_next     = AW'(k_reg - 1'b1);
                    pv_next    = rd_data_a;
                    j_next     = n_last;
                    state_next = ST_SUCC_RD;
                end else begin
                    k_next     = AW'(k_reg - 1'b1);
                    state_next = ST_FIND_RD;
                end
            end
            ST_SUCC_RD: begin
                mem_ctl.rd_en = 1'b1;
                rd_addr_a     = j_reg;
                state_next    = ST_SUCC_CMP;
            end
            ST_SUCC_CMP: begin
                if (cmp_lt) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = p_reg;
                    wr_data       = rd_data_a;
                    lo_next       = AW'(p_reg + 1'b1);
                    state_next    = ST_SWAP2;
                end else begin
                    j_next     = AW'(j_reg - 1'b1);
                    state_next = ST_SUCC_RD;
                end
            end
            ST_SWAP2: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = j_reg;
                wr_data       = pv_reg;
                j_next        = n_last;
                state_next    = ST_REV_RD;
            end
            ST_REV_RD: begin
                if (lo_reg < j_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr_a     = lo_reg;
                    rd_addr_b     = j_reg;
                    state_next    = ST_REV_W1;
                end else begin
                    adv_next   = 1'b1;
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_REV_W1: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = lo_reg;
                wr_data       = rd_data_b;
                state_next    = ST_REV_W2;
            end
            ST_REV_W2: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = j_reg;
                wr_data       = rd_data_a;
                lo_next       = AW'(lo_reg + 1'b1);
                j_next        = AW'(j_reg - 1'b1);
                state_next    = ST_REV_RD;
            end
            ST_EMIT_RD: begin
                // output register is empty by the next cycle
                if (out_free) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr_a     = k_reg;
                    state_next    = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                out_load = 1'b1;
                if (k_reg == n_last) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next     = AW'(k_reg + 1'b1);
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : npg_ctrl

`default_nettype wire

[sv/next_permutation_generator_top.sv]
// ----------------------------------------------------------------------------
// next_permutation_generator_top
// Lexicographic next permutation over a stored vector, one element a result.
// ----------------------------------------------------------------------------
// load transfer: written to the store at acceptance, no result
// step: ascent scan and successor scan, one compare at a time, then the two swap
//   writes, the tail reversal a pair at a time, and the readout of every element
// next transfer is taken once the last result sits in the output register
// reset: sequencer idle, output empty, elem_count 8; store contents undefined
`default_nettype none

module next_permutation_generator_top #(
    parameter int MAX_ELEMS = npg_pkg::MAX_ELEMS_DEF,
    parameter int ELEM_BITS = npg_pkg::ELEM_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [npg_pkg::COUNT_FW-1:0]   cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] elem_index, [18:3] elem_value, [23:19] zero
    input  wire logic [npg_pkg::TDATA_W-1:0]    s_tdata,
    // [0] op
    input  wire logic [npg_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [2:0] out_index, [18:3] out_value, [23:19] zero
    output logic      [npg_pkg::TDATA_W-1:0]    m_tdata,
    // [0] advanced
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import npg_pkg::*;

    localparam int AW    = $clog2(MAX_ELEMS);
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);

    logic [COUNT_FW-1:0]  elem_count_reg;
    npg_mem_ctl_t         mem_ctl;
    logic [AW-1:0]        wr_addr;
    logic [ELEM_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [ELEM_BITS-1:0] rd_data_a;
    logic [ELEM_BITS-1:0] rd_data_b;
    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic [AW-1:0]        out_pos;
    logic [ELEM_BITS-1:0] out_elem;
    logic                 out_adv;
    logic                 out_last;

    logic                 m_valid_reg;
    logic [IDX_FW-1:0]    m_index_reg;
    logic [VAL_FW-1:0]    m_value_reg;
    logic                 m_adv_reg;
    logic                 m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_count_reg <= ELEM_COUNT_RST;
        end else if (cfg_wr_en) begin
            elem_count_reg <= cfg_wr_data;
        end
    end

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    npg_ctrl #(
        .MAX_ELEMS (MAX_ELEMS),
        .ELEM_BITS (ELEM_BITS),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_op      (s_tuser),
        .in_idx     (s_tdata[IDX_FW-1:0]),
        .in_val     (s_tdata[IDX_FW+VAL_FW-1:IDX_FW]),
        .elem_count (elem_count_reg),
        .in_ready   (s_tready),
        .mem_ctl    (mem_ctl),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_pos    (out_pos),
        .out_elem   (out_elem),
        .out_adv    (out_adv),
        .out_last   (out_last)
    );

    npg_mem #(
        .DEPTH (MAX_ELEMS),
        .WIDTH (ELEM_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .ctl       (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= IDX_FW'(out_pos);
            m_value_reg <= VAL_FW'(out_elem);
            m_adv_reg   <= out_adv;
            m_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_W - IDX_FW - VAL_FW)'(0), m_value_reg, m_index_reg};
    assign m_tuser  = m_adv_reg;
    assign m_tlast  = m_last_reg;

endmodule : next_permutation_generator_top

`default_nettype wire

[bench/next_permutation_generator_top_tb.sv]
// ----------------------------------------------------------------------------
// next_permutation_generator_top_tb
// Loads element vectors, steps them through their lexicographic successors
// under several element counts and checks every emitted element against an
// in-bench predictor, with random bursts on the input and stalls on the output.
// ----------------------------------------------------------------------------
module next_permutation_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ELEMS        = npg_pkg::MAX_ELEMS_DEF;
    localparam int VAL_W          = npg_pkg::VAL_FW;
    localparam int IDX_W          = npg_pkg::IDX_FW;
    localparam int PAD_W          = npg_pkg::TDATA_W - IDX_W - VAL_W;
    localparam int TOTAL_ITEMS    = 310;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             adv;
        logic             last;
    } elem_result_t;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [npg_pkg::COUNT_FW-1:0]        cfg_wr_data = '0;
    logic                                s_tvalid    = 1'b0;
    logic                                s_tready;
    logic [npg_pkg::TDATA_W-1:0]         s_tdata     = '0;
    logic [npg_pkg::OP_W-1:0]            s_tuser     = npg_pkg::OP_LOAD;
    logic                                m_tvalid;
    logic                                m_tready    = 1'b0;
    logic [npg_pkg::TDATA_W-1:0]         m_tdata;
    logic                                m_tuser;
    logic                                m_tlast;

    // mirror of the block's vector and element count
    logic [VAL_W-1:0]             perm_mirror [N_ELEMS];
    logic [npg_pkg::COUNT_FW-1:0] count_mirror = npg_pkg::ELEM_COUNT_RST;
    elem_result_t                 expected_elems [$];

    int errors      = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int hold_reqs   = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int seg_left    = 0;
    int rx_pct      = 100;
    int idle_cycles = 0;

    next_permutation_generator_top #(
        .MAX_ELEMS (N_ELEMS),
        .ELEM_BITS (VAL_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int elems_in_use();
        if (count_mirror == 0) return 1;
        if (count_mirror > N_ELEMS) return N_ELEMS;
        return count_mirror;
    endfunction

    // rewrite the mirror into its successor and queue the emitted run
    function automatic void predict_next_perm();
        int               n;
        int               i;
        int               j;
        logic [VAL_W-1:0] t;
        logic             adv;
        elem_result_t     r;
        n = elems_in_use();
        i = n - 1;
        while (i > 0 && perm_mirror[i-1] >= perm_mirror[i]) i--;
        adv = (i != 0);
        if (adv) begin
            j = n - 1;
            while (perm_mirror[j] <= perm_mirror[i-1]) j--;
            t = perm_mirror[i-1];
            perm_mirror[i-1] = perm_mirror[j];
            perm_mirror[j] = t;
            j = n - 1;
            while (i < j) begin
                t = perm_mirror[i];
                perm_mirror[i] = perm_mirror[j];
                perm_mirror[j] = t;
                i++;
                j--;
            end
        end
        for (int k = 0; k < n; k++) begin
            r.idx   = IDX_W'(k);
            r.value = perm_mirror[k];
            r.adv   = adv;
            r.last  = (k == n - 1);
            expected_elems.push_back(r);
        end
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(input logic pool,
                                                     input logic [VAL_W-1:0] base);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            // pool values sit close together so repeats are frequent
            default: return pool ? base + VAL_W'($urandom_range(0, 2)) : VAL_W'($urandom);
        endcase
    endfunction

    // one input transfer, with random gaps between bursts
    task automatic push_item(input logic [npg_pkg::OP_W-1:0] op,
                             input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] value);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, value, idx};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
        if (op == npg_pkg::OP_LOAD) begin
            perm_mirror[idx] = value;
        end else begin
            predict_next_perm();
        end
    endtask

    task automatic push_step();
        push_item(npg_pkg::OP_STEP, IDX_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_elems.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_count(input logic [npg_pkg::COUNT_FW-1:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        count_mirror = value;
    endtask

    task automatic test_directed_edges();
        logic [VAL_W-1:0] init_vals [N_ELEMS] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
                                                  16'h00FF, 16'h7FFE, 16'hAAAA, 16'h5555};
        for (int k = 0; k < N_ELEMS; k++) push_item(npg_pkg::OP_LOAD, IDX_W'(k), init_vals[k]);
        push_step();
        // single element, zero count and oversized count
        set_count(4'd1);
        push_step();
        set_count(4'd0);
        push_step();
        set_count(4'd15);
        push_step();
        // last permutation stays put
        set_count(4'd3);
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'd30);
        push_item(npg_pkg::OP_LOAD, 3'd1, 16'd20);
        push_item(npg_pkg::OP_LOAD, 3'd2, 16'd10);
        push_step();
        push_step();
        // repeated values
        push_item(npg_pkg::OP_LOAD, 3'd1, 16'd10);
        push_step();
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'd10);
        push_step();
        push_item(npg_pkg::OP_LOAD, 3'd2, 16'd11);
        push_step();
    endtask

    task automatic test_small_walks();
        set_count(4'd4);
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'd1);
        push_item(npg_pkg::OP_LOAD, 3'd1, 16'd2);
        push_item(npg_pkg::OP_LOAD, 3'd2, 16'd2);
        push_item(npg_pkg::OP_LOAD, 3'd3, 16'd3);
        repeat (13) push_step();
        set_count(4'd3);
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'd7);
        push_item(npg_pkg::OP_LOAD, 3'd1, 16'd8);
        push_item(npg_pkg::OP_LOAD, 3'd2, 16'd9);
        repeat (7) push_step();
    endtask

    // receiver holds off while steps keep coming, so the input must stall
    task automatic test_output_backpressure();
        set_count(4'd8);
        hold_reqs++;
        @(posedge aclk);
        repeat (6) push_step();
        push_item(npg_pkg::OP_LOAD, 3'd7, 16'h0001);
        repeat (6) push_step();
    endtask

    task automatic test_sender_pause();
        set_count(4'd2);
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'h0100);
        push_item(npg_pkg::OP_LOAD, 3'd1, 16'h0200);
        repeat (3) push_step();
        wait_drained(1);
        repeat (3) push_step();
        push_item(npg_pkg::OP_LOAD, 3'd0, 16'h0300);
        push_step();
    endtask

    task automatic test_random_phases();
        logic [npg_pkg::COUNT_FW-1:0] first_counts [4] = '{4'd0, 4'd15, 4'd1, 4'd8};
        int               phase = 0;
        int               n;
        int               steps;
        logic             pool;
        logic [VAL_W-1:0] base;
        while (items_sent < TOTAL_ITEMS) begin
            if (phase < 4) begin
                set_count(first_counts[phase]);
            end else begin
                set_count(npg_pkg::COUNT_FW'($urandom_range(0, 15)));
            end
            phase++;
            n    = elems_in_use();
            pool = 1'($urandom_range(0, 1));
            base = VAL_W'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                // fresh vector then a run of steps, with the odd stray load
                for (int k = 0; k < n; k++) begin
                    push_item(npg_pkg::OP_LOAD, IDX_W'(k), pick_value(pool, base));
                end
                steps = $urandom_range(4, 18);
                for (int s = 0; s < steps; s++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_item(npg_pkg::OP_LOAD, IDX_W'($urandom), pick_value(pool, base));
                    end else begin
                        push_step();
                    end
                end
            end else begin
                repeat ($urandom_range(8, 24)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        push_step();
                    end else begin
                        push_item(npg_pkg::OP_LOAD, IDX_W'($urandom), pick_value(pool, base));
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_small_walks();
        test_output_backpressure();
        test_sender_pause();
        test_random_phases();
        wait_drained(SETTLE_CYCLES);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver: random ready in segments, calm segments, and requested hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ack != hold_reqs) begin
            hold_ack  <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(16, 160);
                rx_pct   <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(15, 85);
            end else begin
                seg_left <= seg_left - 1;
            end
            m_tready <= ($urandom_range(1, 100) <= rx_pct);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // outputs are stable at the falling edge; the transfer lands on the next rise
    always @(negedge aclk) begin : check_out
        elem_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_elems.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = expected_elems.pop_front();
                check_field("out_index", want.idx, m_tdata[IDX_W-1:0]);
                check_field("out_value", want.value, m_tdata[IDX_W +: VAL_W]);
                check_field("advanced", want.adv, m_tuser);
                check_field("last", want.last, m_tlast);
                check_field("tdata padding", 0, m_tdata[npg_pkg::TDATA_W-1 -: PAD_W]);
            end
        end
    end

    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[filelist.f]
sv/npg_pkg.sv
sv/npg_mem.sv
sv/npg_ctrl.sv
sv/next_permutation_generator_top.sv
bench/next_permutation_generator_top_tb.sv
